>>> rtl/kmt_pkg.sv
// shared types and constants of the keyed message table
package kmt_pkg;

  localparam int KEY_W = 8;
  localparam int MSG_W = 15;

  localparam logic [1:0] REQ_LOOKUP = 2'd0;
  localparam logic [1:0] REQ_SET    = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  typedef enum logic [2:0] {
    ST_HIT      = 3'd0,
    ST_MISS     = 3'd1,
    ST_INSERTED = 3'd2,
    ST_UPDATED  = 3'd3,
    ST_REJECTED = 3'd4,
    ST_FULL     = 3'd5,
    ST_CLEARED  = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_RESP
  } fsm_t;

  typedef struct packed {
    logic [KEY_W-1:0] family;
    logic [KEY_W-1:0] start_rung;
    logic [KEY_W-1:0] jump_steps;
    logic [MSG_W-1:0] message;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic    latch_req;
    logic    idx_clr;
    logic    idx_inc;
    logic    rd_en;
    logic    cap_msg;
    logic    wr_upd;
    logic    wr_app;
    logic    cnt_clr;
    logic    load_out;
    status_t res_status;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       key_ok;
    logic       scan_done;
    logic       match;
    logic       full;
    logic       out_free;
  } stat_t;

endpackage

>>> rtl/kmt_if.sv
// request and result channel interfaces
interface kmt_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                req_type;
  logic [kmt_pkg::KEY_W-1:0] family;
  logic [kmt_pkg::KEY_W-1:0] start_rung;
  logic [kmt_pkg::KEY_W-1:0] jump_steps;
  logic [kmt_pkg::MSG_W-1:0] message_in;

  modport source (output valid, req_type, family, start_rung, jump_steps, message_in,
                  input ready);
  modport sink (input valid, req_type, family, start_rung, jump_steps, message_in,
                output ready);
endinterface

interface kmt_out_if;
  logic                      valid;
  logic                      ready;
  kmt_pkg::status_t          status;
  logic [kmt_pkg::MSG_W-1:0] message_out;

  modport source (output valid, status, message_out, input ready);
  modport sink (input valid, status, message_out, output ready);
endinterface

>>> rtl/kmt_ram.sv
// generic single-write, single-read ram with registered read data
module kmt_ram #(
  parameter int WIDTH = 39,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/kmt_dp.sv
// datapath: request registers, scan index, entry count, entry ram and result register
module kmt_dp #(
  parameter int CAPACITY  = 1024,
  parameter int FAMILIES  = 4,
  parameter int RUNG_LAST = 100
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [1:0]                in_req_type,
  input  logic [kmt_pkg::KEY_W-1:0] in_family,
  input  logic [kmt_pkg::KEY_W-1:0] in_start_rung,
  input  logic [kmt_pkg::KEY_W-1:0] in_jump_steps,
  input  logic [kmt_pkg::MSG_W-1:0] in_message_in,
  input  kmt_pkg::cmd_t             cmd,
  output kmt_pkg::stat_t            stat,
  output logic                      out_valid,
  input  logic                      out_ready,
  output kmt_pkg::status_t          out_status,
  output logic [kmt_pkg::MSG_W-1:0] out_message_out
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [1:0]                req_type_r;
  logic [kmt_pkg::KEY_W-1:0] family_r;
  logic [kmt_pkg::KEY_W-1:0] start_rung_r;
  logic [kmt_pkg::KEY_W-1:0] jump_steps_r;
  logic [kmt_pkg::MSG_W-1:0] message_r;
  logic [CW-1:0]             idx_r;
  logic [CW-1:0]             count_r;
  logic [kmt_pkg::MSG_W-1:0] hit_msg_r;
  logic                      out_valid_r;
  kmt_pkg::status_t          out_status_r;
  logic [kmt_pkg::MSG_W-1:0] out_msg_r;

  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  kmt_pkg::entry_t           ram_wdata;
  kmt_pkg::entry_t           ram_rdata;

  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      req_type_r   <= in_req_type;
      family_r     <= in_family;
      start_rung_r <= in_start_rung;
      jump_steps_r <= in_jump_steps;
      message_r    <= in_message_in;
    end
    if (cmd.cap_msg) begin
      hit_msg_r <= ram_rdata.message;
    end
    if (cmd.load_out) begin
      out_status_r <= cmd.res_status;
      out_msg_r    <= (cmd.res_status == kmt_pkg::ST_HIT) ? hit_msg_r : '0;
    end
    if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.cnt_clr) begin
        count_r <= '0;
      end else if (cmd.wr_app) begin
        count_r <= count_r + CW'(1);
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // update writes at the matched slot, append at the fill count
  assign ram_we               = cmd.wr_upd | cmd.wr_app;
  assign ram_waddr            = cmd.wr_app ? count_r[AW-1:0] : idx_r[AW-1:0];
  assign ram_wdata.family     = family_r;
  assign ram_wdata.start_rung = start_rung_r;
  assign ram_wdata.jump_steps = jump_steps_r;
  assign ram_wdata.message    = message_r;

  kmt_ram #(
    .WIDTH (kmt_pkg::ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd_en),
    .raddr (idx_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    stat.req_type  = req_type_r;
    stat.key_ok    = (family_r < kmt_pkg::KEY_W'(FAMILIES))
                   && (start_rung_r <= kmt_pkg::KEY_W'(RUNG_LAST))
                   && (jump_steps_r != '0)
                   && (jump_steps_r <= kmt_pkg::KEY_W'(RUNG_LAST));
    stat.scan_done = (idx_r == count_r);
    stat.match     = (ram_rdata.family == family_r)
                   && (ram_rdata.start_rung == start_rung_r)
                   && (ram_rdata.jump_steps == jump_steps_r);
    stat.full      = (count_r == CW'(CAPACITY));
    stat.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_message_out = out_msg_r;

endmodule

>>> rtl/kmt_ctrl.sv
// controller state machine that sequences decode, scan, write and response
module kmt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  kmt_pkg::stat_t stat,
  output kmt_pkg::cmd_t  cmd
);

  kmt_pkg::fsm_t    state_r, state_nxt;
  kmt_pkg::status_t res_r, res_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kmt_pkg::S_IDLE;
      res_r   <= kmt_pkg::ST_REJECTED;
    end else begin
      state_r <= state_nxt;
      res_r   <= res_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    res_nxt   = res_r;
    unique case (state_r)
      kmt_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = kmt_pkg::S_DECODE;
        end
      end
      kmt_pkg::S_DECODE: begin
        unique case (stat.req_type)
          kmt_pkg::REQ_LOOKUP: begin
            state_nxt = kmt_pkg::S_SCAN_RD;
          end
          kmt_pkg::REQ_SET: begin
            if (stat.key_ok) begin
              state_nxt = kmt_pkg::S_SCAN_RD;
            end else begin
              res_nxt   = kmt_pkg::ST_REJECTED;
              state_nxt = kmt_pkg::S_RESP;
            end
          end
          kmt_pkg::REQ_CLEAR: begin
            res_nxt   = kmt_pkg::ST_CLEARED;
            state_nxt = kmt_pkg::S_RESP;
          end
          default: begin
            res_nxt   = kmt_pkg::ST_REJECTED;
            state_nxt = kmt_pkg::S_RESP;
          end
        endcase
      end
      kmt_pkg::S_SCAN_RD: begin
        if (stat.scan_done) begin
          state_nxt = kmt_pkg::S_RESP;
          if (stat.req_type != kmt_pkg::REQ_SET) begin
            res_nxt = kmt_pkg::ST_MISS;
          end else if (stat.full) begin
            res_nxt = kmt_pkg::ST_FULL;
          end else begin
            res_nxt = kmt_pkg::ST_INSERTED;
          end
        end else begin
          state_nxt = kmt_pkg::S_SCAN_CMP;
        end
      end
      kmt_pkg::S_SCAN_CMP: begin
        if (stat.match) begin
          state_nxt = kmt_pkg::S_RESP;
          res_nxt   = (stat.req_type == kmt_pkg::REQ_SET) ? kmt_pkg::ST_UPDATED
                                                         : kmt_pkg::ST_HIT;
        end else begin
          state_nxt = kmt_pkg::S_SCAN_RD;
        end
      end
      kmt_pkg::S_RESP: begin
        if (stat.out_free) begin
          state_nxt = kmt_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = kmt_pkg::S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.res_status = res_r;
    unique case (state_r)
      kmt_pkg::S_IDLE: begin
        in_ready      = 1'b1;
        cmd.latch_req = in_valid;
        cmd.idx_clr   = in_valid;
      end
      kmt_pkg::S_DECODE: begin
        cmd.cnt_clr = (stat.req_type == kmt_pkg::REQ_CLEAR);
      end
      kmt_pkg::S_SCAN_RD: begin
        cmd.rd_en  = !stat.scan_done;
        cmd.wr_app = stat.scan_done && (stat.req_type == kmt_pkg::REQ_SET) && !stat.full;
      end
      kmt_pkg::S_SCAN_CMP: begin
        cmd.cap_msg = stat.match && (stat.req_type != kmt_pkg::REQ_SET);
        cmd.wr_upd  = stat.match && (stat.req_type == kmt_pkg::REQ_SET);
        cmd.idx_inc = !stat.match;
      end
      kmt_pkg::S_RESP: begin
        cmd.load_out = stat.out_free;
      end
      default: begin
        cmd.res_status = res_r;
      end
    endcase
  end

endmodule

>>> rtl/keyed_message_table.sv
// top level of the keyed message table
//
// a table of (family, start_rung, jump_steps) keys, each mapped to a 15-bit
// message number, searched front to back over the filled entries
// in_ch carries one request per beat: lookup, set or clear; out_ch returns
// exactly one result beat per request with a status code and, on a hit, the
// stored message (zero otherwise)
// one request is worked at a time; in_ch.ready is high only while idle
// a clear, an unused code or a rejected set skips the walk; a hit or an
// update ends it at the matched slot, and a miss, an append or a full drop
// walks all filled entries; the walk is bound by the single read port of
// the entry ram, one read plus one compare per entry; the next request is
// taken in the cycle after its result loads
// results sit in an output register; a request is taken while an earlier
// result still waits, and a stalled receiver holds the next result back
// in the response state until the register frees up
// reset empties the table (fill count to zero) and drops any pending
// result; entry ram contents are not cleared, there is no clearing pass
module keyed_message_table #(
  parameter int CAPACITY  = 1024,
  parameter int FAMILIES  = 4,
  parameter int RUNG_LAST = 100
) (
  input  logic       clk,
  input  logic       rst_n,
  kmt_in_if.sink     in_ch,
  kmt_out_if.source  out_ch
);

  kmt_pkg::cmd_t  cmd;
  kmt_pkg::stat_t stat;

  // sequencing: decode, walk the entries, write, respond
  kmt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // request capture, entry ram, fill count and the result register
  kmt_dp #(
    .CAPACITY  (CAPACITY),
    .FAMILIES  (FAMILIES),
    .RUNG_LAST (RUNG_LAST)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_req_type     (in_ch.req_type),
    .in_family       (in_ch.family),
    .in_start_rung   (in_ch.start_rung),
    .in_jump_steps   (in_ch.jump_steps),
    .in_message_in   (in_ch.message_in),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_status      (out_ch.status),
    .out_message_out (out_ch.message_out)
  );

endmodule
